// ----- rtl/hwm_pkg.sv -----
// shared types and constants of the heartbeat watchdog monitor
package hwm_pkg;

   // request kinds carried in the request tuser
   typedef enum logic [1:0] {
      REQ_REGISTER  = 2'd0,
      REQ_HEARTBEAT = 2'd1,
      REQ_CHECK     = 2'd2
   } req_kind_type;

   // result kinds carried in the response tuser
   typedef enum logic [1:0] {
      RESULT_ACK     = 2'd0,
      RESULT_TIMEOUT = 2'd1,
      RESULT_SUMMARY = 2'd2
   } result_kind_type;

   // csr register index of the default timeout
   localparam logic CSR_DEFAULT_TIMEOUT = 1'b0;

   // default timeout after reset, in ticks
   localparam logic [31:0] DEFAULT_TIMEOUT_RESET = 32'd1000;

   // field widths
   localparam int CLIENT_W = 8;
   localparam int TIME_W   = 32;
   localparam int ENTRY_W  = CLIENT_W + 2 * TIME_W;

   // controller to datapath commands
   typedef struct packed {
      logic            load_req;
      logic            clear_idx;
      logic            step_idx;
      logic            reg_write;
      logic            beat_write;
      logic            deactivate;
      logic            emit;
      result_kind_type emit_kind;
      logic            emit_accepted;
   } hwm_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic walk_end;
      logic table_full;
      logic hit;
      logic expired;
      logic out_free;
   } hwm_status_type;

endpackage

// ----- rtl/hwm_ram.sv -----
// generic single write port, single read port ram with registered read
module hwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/hwm_ctrl.sv -----
// controller state machine of the heartbeat watchdog monitor
module hwm_ctrl
   import hwm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic [1:0]     req_tuser,
   input  hwm_status_type status,
   output logic           req_tready,
   output hwm_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_REGISTER = 5'b00010,
      ST_BEAT     = 5'b00100,
      ST_CHECK    = 5'b01000,
      ST_SUMMARY  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.emit_kind = RESULT_ACK;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req  = 1'b1;
               cmd.clear_idx = 1'b1;
               unique case (req_tuser)
                  REQ_REGISTER:  state_in = ST_REGISTER;
                  REQ_HEARTBEAT: state_in = ST_BEAT;
                  REQ_CHECK:     state_in = ST_CHECK;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_REGISTER: begin
            if (status.out_free) begin
               cmd.emit          = 1'b1;
               cmd.emit_kind     = RESULT_ACK;
               cmd.emit_accepted = !status.table_full;
               cmd.reg_write     = !status.table_full;
               state_in          = ST_IDLE;
            end
         end
         ST_BEAT: begin
            if (status.walk_end || status.hit) begin
               if (status.out_free) begin
                  cmd.emit          = 1'b1;
                  cmd.emit_kind     = RESULT_ACK;
                  cmd.emit_accepted = status.hit;
                  cmd.beat_write    = status.hit;
                  state_in          = ST_IDLE;
               end
            end else begin
               cmd.step_idx = 1'b1;
            end
         end
         ST_CHECK: begin
            if (status.walk_end) begin
               state_in = ST_SUMMARY;
            end else if (status.expired) begin
               // hold the entry until the timeout result can be loaded
               if (status.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_kind  = RESULT_TIMEOUT;
                  cmd.deactivate = 1'b1;
                  cmd.step_idx   = 1'b1;
               end
            end else begin
               cmd.step_idx = 1'b1;
            end
         end
         ST_SUMMARY: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = RESULT_SUMMARY;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/hwm_dp.sv -----
// datapath: request registers, client table, walk index and result register
module hwm_dp
   import hwm_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  hwm_cmd_type    cmd,
   input  logic [71:0]    req_tdata,
   input  logic [31:0]    default_timeout,
   input  logic           rsp_tready,
   output hwm_status_type status,
   output logic           rsp_tvalid,
   output logic [15:0]    rsp_tdata,
   output logic [1:0]     rsp_tuser,
   output logic           rsp_tlast
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   // request payload
   logic [CLIENT_W-1:0] id_ff;
   logic [TIME_W-1:0]   tmo_ff;
   logic [TIME_W-1:0]   now_ff;

   // table control state
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [MAX_ENTRIES-1:0] active_ff, active_in;

   // table memory port signals
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [CLIENT_W-1:0] rd_client;
   logic [TIME_W-1:0]   rd_beat;
   logic [TIME_W-1:0]   rd_timeout;
   logic [TIME_W-1:0]   elapsed;
   logic                cur_active;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   result_kind_type     rsp_kind_ff;
   logic                rsp_acc_ff;
   logic [CLIENT_W-1:0] rsp_id_ff;
   logic                rsp_healthy_ff;
   logic                rsp_last_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         id_ff  <= req_tdata[7:0];
         tmo_ff <= req_tdata[39:8];
         now_ff <= req_tdata[71:40];
      end
   end

   // table entry layout: client, last beat, timeout
   assign rd_client  = rd_data[ENTRY_W-1 -: CLIENT_W];
   assign rd_beat    = rd_data[2*TIME_W-1 -: TIME_W];
   assign rd_timeout = rd_data[TIME_W-1:0];

   // walk index; the memory reads ahead at the next index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if (cmd.step_idx) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   // memory write selection
   always_comb begin
      wr_en   = cmd.reg_write || cmd.beat_write;
      wr_addr = cmd.reg_write ? count_ff[AW-1:0] : idx_ff[AW-1:0];
      if (cmd.reg_write) begin
         wr_data = {id_ff, now_ff, (tmo_ff != '0) ? tmo_ff : default_timeout};
      end else begin
         wr_data = {rd_client, now_ff, rd_timeout};
      end
   end

   hwm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[AW-1:0]),
      .rd_data (rd_data)
   );

   // entry evaluation with wrapping elapsed time
   assign elapsed    = now_ff - rd_beat;
   assign cur_active = active_ff[idx_ff[AW-1:0]];

   always_comb begin
      status.walk_end   = idx_ff >= count_ff;
      status.table_full = count_ff == CW'(MAX_ENTRIES);
      status.hit        = !status.walk_end && cur_active && (rd_client == id_ff);
      status.expired    = !status.walk_end && cur_active && (elapsed > rd_timeout);
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // fill count and active flags
   always_comb begin
      count_in  = count_ff;
      active_in = active_ff;
      if (cmd.reg_write) begin
         count_in                     = count_ff + CW'(1);
         active_in[count_ff[AW-1:0]] = 1'b1;
      end
      if (cmd.deactivate) begin
         active_in[idx_ff[AW-1:0]] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= '0;
         idx_ff    <= '0;
      end else begin
         count_ff  <= count_in;
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, unused fields forced to zero
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff    <= cmd.emit_kind;
         rsp_acc_ff     <= (cmd.emit_kind == RESULT_ACK) && cmd.emit_accepted;
         rsp_id_ff      <= (cmd.emit_kind == RESULT_TIMEOUT) ? rd_client : '0;
         rsp_healthy_ff <= (cmd.emit_kind == RESULT_SUMMARY) &&
                           ((|active_ff) || (count_ff == '0));
         rsp_last_ff    <= cmd.emit_kind != RESULT_TIMEOUT;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_healthy_ff, rsp_id_ff, rsp_acc_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/heartbeat_watchdog_monitor.sv -----
// top level of the multi-channel heartbeat watchdog monitor
//
// Requests enter on the req_ stream: req_tuser selects register, heartbeat
// or check, req_tdata carries client id, timeout and time stamp. Results
// leave on the rsp_ stream: result kind on rsp_tuser, rsp_tlast on the
// final result of each request. The default timeout sits in a csr at
// byte address 0 of the APB-style csr_ port; it must be written only while
// idle, which the block itself does not enforce. One request is processed
// at a time. A register request passes through the register state, which
// loads its acknowledge into the result register. Heartbeat and check walk
// the client table one entry per cycle, unless a result waits, through the
// table memory read port: a heartbeat ends its walk at the first matching
// active entry or the end of the filled table, and a check steps past an
// expired entry as it loads its timeout result. The next request is accepted
// in the cycle after the final result is loaded. The table fills in request
// order up to MAX_ENTRIES entries and is never cleared except by reset. A
// result register sits on the output; when the receiver holds rsp_tready low, the
// walk pauses on the next expired entry or final result.
// Reset empties the table, clears all active flags, drops any pending result
// and restores the default timeout to 1000 ticks.
module heartbeat_watchdog_monitor
   import hwm_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // client_id[7:0], timeout_value[39:8], time_stamp[71:40]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // accepted[0], expired_id[8:1], healthy[9], zero[15:10]
   output logic [1:0]  rsp_tuser,   // result_kind[1:0]
   output logic        rsp_tlast,
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0]    default_timeout_ff;
   logic           csr_write;
   hwm_cmd_type    cmd;
   hwm_status_type status;

   // csr write and read
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_timeout_ff <= DEFAULT_TIMEOUT_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_DEFAULT_TIMEOUT)) begin
         default_timeout_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_DEFAULT_TIMEOUT) ? default_timeout_ff : '0;

   // controller
   hwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // datapath
   hwm_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_tdata       (req_tdata),
      .default_timeout (default_timeout_ff),
      .rsp_tready      (rsp_tready),
      .status          (status),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

   // a result is never loaded over one that is still waiting
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> status.out_free)
      else $error("result loaded while output register busy");

   // a full table is never written
   assert property (@(posedge clock) disable iff (reset) cmd.reg_write |-> !status.table_full)
      else $error("register write into full table");

   // a heartbeat only refreshes a matching active entry inside the table
   assert property (@(posedge clock) disable iff (reset)
      cmd.beat_write |-> (status.hit && !status.walk_end))
      else $error("heartbeat write without a hit");

   // every deactivation comes with its timeout result
   assert property (@(posedge clock) disable iff (reset)
      cmd.deactivate |-> (status.expired && cmd.emit && (cmd.emit_kind == RESULT_TIMEOUT)))
      else $error("entry deactivated without timeout result");

endmodule
